FILE: sv/cdq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_pkg
// shared types and constants of the circular deque
// ----------------------------------------------------------------------------
package cdq_pkg;

   // ring capacity, a power of two so slot arithmetic wraps by itself
   localparam int CAPACITY = 16;
   localparam int ELEM_W   = 32;
   localparam int SLOT_W   = $clog2(CAPACITY);
   localparam int COUNT_W  = $clog2(CAPACITY + 1);
   localparam int POS_W    = 4;
   localparam int OP_W     = 3;
   localparam int STATUS_W = 2;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_GET        = 3'd4,
      OP_PUT        = 3'd5
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   // sequencing commands from controller to datapath
   typedef struct packed {
      logic capture;
      logic execute;
      logic respond;
   } ctl_cmd_type;

endpackage

FILE: sv/cdq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_ctrl
// sequencer: capture, execute against the ring, respond
// ----------------------------------------------------------------------------
module cdq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output cdq_pkg::ctl_cmd_type cmd
);
   import cdq_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_EXEC = 3'b010,
      S_RESP = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_EXEC;
         end
         S_EXEC: state_in = S_RESP;
         S_RESP: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   assign busy        = (state_ff != S_IDLE);
   assign cmd.capture = (state_ff == S_IDLE) && start;
   assign cmd.execute = (state_ff == S_EXEC);
   assign cmd.respond = (state_ff == S_RESP);

endmodule

FILE: sv/cdq_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_datapath
// head and count registers, slot arithmetic and the ring store
// ----------------------------------------------------------------------------
module cdq_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  cdq_pkg::ctl_cmd_type           cmd,
   input  logic [cdq_pkg::OP_W-1:0]       req_op,
   input  logic [cdq_pkg::POS_W-1:0]      req_position,
   input  logic [cdq_pkg::ELEM_W-1:0]     req_value_in,
   output logic                           rsp_valid,
   output logic [cdq_pkg::ELEM_W-1:0]     rsp_value_out,
   output logic [cdq_pkg::STATUS_W-1:0]   rsp_status,
   output logic [cdq_pkg::COUNT_W-1:0]    rsp_count
);
   import cdq_pkg::*;

   // captured word
   op_type              op_ff;
   logic [POS_W-1:0]    pos_ff;
   logic [ELEM_W-1:0]   val_ff;

   // deque state
   logic [SLOT_W-1:0]   head_ff, head_in;
   logic [COUNT_W-1:0]  count_ff, count_in;

   // execute results held for the response cycle
   logic [SLOT_W-1:0]   slot_ff;
   status_type          status_ff, status_in;
   logic                from_mem_ff, from_mem_in;
   logic                from_req_ff, from_req_in;
   logic                put_ff, put_in;

   logic [ELEM_W-1:0]   mem [CAPACITY];
   logic [ELEM_W-1:0]   rd_data_ff;

   logic [SLOT_W-1:0]   slot_c;
   logic                push_we;
   logic                mem_re;
   logic                full, empty, in_range;
   logic [COUNT_W-1:0]  count_dec;

   assign full      = (count_ff == COUNT_W'(CAPACITY));
   assign empty     = (count_ff == '0);
   assign in_range  = (COUNT_W'(pos_ff) < count_ff);
   assign count_dec = count_ff - COUNT_W'(1);

   always_comb begin
      head_in     = head_ff;
      count_in    = count_ff;
      status_in   = ST_OK;
      from_mem_in = 1'b0;
      from_req_in = 1'b0;
      put_in      = 1'b0;
      slot_c      = head_ff;
      push_we     = 1'b0;
      mem_re      = 1'b0;
      unique case (op_ff)
         OP_PUSH_FRONT: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               slot_c      = head_ff - SLOT_W'(1);
               head_in     = slot_c;
               count_in    = count_ff + COUNT_W'(1);
               push_we     = 1'b1;
               from_req_in = 1'b1;
            end
         end
         OP_PUSH_BACK: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               slot_c      = head_ff + count_ff[SLOT_W-1:0];
               count_in    = count_ff + COUNT_W'(1);
               push_we     = 1'b1;
               from_req_in = 1'b1;
            end
         end
         OP_POP_FRONT: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               slot_c      = head_ff;
               head_in     = head_ff + SLOT_W'(1);
               count_in    = count_dec;
               mem_re      = 1'b1;
               from_mem_in = 1'b1;
            end
         end
         OP_POP_BACK: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               slot_c      = head_ff + count_dec[SLOT_W-1:0];
               count_in    = count_dec;
               mem_re      = 1'b1;
               from_mem_in = 1'b1;
            end
         end
         OP_GET: begin
            if (!in_range) begin
               status_in = ST_RANGE;
            end else begin
               slot_c      = head_ff + SLOT_W'(pos_ff);
               mem_re      = 1'b1;
               from_mem_in = 1'b1;
            end
         end
         OP_PUT: begin
            if (!in_range) begin
               status_in = ST_RANGE;
            end else begin
               slot_c      = head_ff + SLOT_W'(pos_ff);
               mem_re      = 1'b1;
               from_mem_in = 1'b1;
               put_in      = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= op_type'(req_op);
         pos_ff <= req_position;
         val_ff <= req_value_in;
      end
   end

   // deque state and execute results
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= '0;
         count_ff    <= '0;
         put_ff      <= 1'b0;
         from_mem_ff <= 1'b0;
         from_req_ff <= 1'b0;
      end else if (cmd.execute) begin
         head_ff     <= head_in;
         count_ff    <= count_in;
         put_ff      <= put_in;
         from_mem_ff <= from_mem_in;
         from_req_ff <= from_req_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         slot_ff   <= slot_c;
         status_ff <= status_in;
      end
   end

   // ring store: pushes write in execute, put writes back in respond
   always_ff @(posedge clock) begin
      if (cmd.execute && push_we) mem[slot_c] <= val_ff;
      else if (cmd.respond && put_ff) mem[slot_ff] <= val_ff;
      if (cmd.execute && mem_re) rd_data_ff <= mem[slot_c];
   end

   assign rsp_valid     = cmd.respond;
   assign rsp_status    = status_ff;
   assign rsp_count     = count_ff;
   assign rsp_value_out = from_mem_ff ? rd_data_ff :
                          from_req_ff ? val_ff     : '0;

endmodule

FILE: sv/circular_deque.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_deque
// double-ended queue of sixteen 32-bit elements kept in a ring store
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. Each word passes
// through the capture edge, an execute cycle that updates head and count and
// reads or writes the ring store (single-port memory with a registered read),
// and a response cycle in which rsp_valid is high for exactly one clock and
// the result stands on the rsp_ ports. The receiver cannot stall, so the
// result must be taken in that cycle. busy stays high from the capture edge
// through the response cycle; a new word can be started in the cycle after
// rsp_valid. Refused operations (push on full, pop on empty, index at or
// beyond the count) leave the state alone, return value zero and report the
// reason in rsp_status. rsp_count is the element count after the operation.
// ----------------------------------------------------------------------------
module circular_deque (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [cdq_pkg::OP_W-1:0]       req_op,
   input  logic [cdq_pkg::POS_W-1:0]      req_position,
   input  logic [cdq_pkg::ELEM_W-1:0]     req_value_in,
   output logic                           rsp_valid,
   output logic [cdq_pkg::ELEM_W-1:0]     rsp_value_out,
   output logic [cdq_pkg::STATUS_W-1:0]   rsp_status,
   output logic [cdq_pkg::COUNT_W-1:0]    rsp_count
);
   import cdq_pkg::*;

   // command bundle from sequencer to datapath
   ctl_cmd_type cmd;

   // sequencer: idle, execute, respond
   cdq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   // head, count, slot arithmetic and ring store
   cdq_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_op        (req_op),
      .req_position  (req_position),
      .req_value_in  (req_value_in),
      .rsp_valid     (rsp_valid),
      .rsp_value_out (rsp_value_out),
      .rsp_status    (rsp_status),
      .rsp_count     (rsp_count)
   );

endmodule

FILE: tb/circular_deque_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_deque_tb
// self-checking bench for the ring-store double-ended queue
// ----------------------------------------------------------------------------
// Words are fed through the start/busy handshake. A scoreboard keeps its own
// copy of the ring, head and count, works out the reply of every accepted
// word and compares it field by field with the replies strobed out on
// rsp_valid. A short directed run covers the refusals and a full fill. Then
// a long random run drifts between filling, draining and mixed traffic,
// under several sender idle rates.
// ----------------------------------------------------------------------------
module circular_deque_tb;
   import cdq_pkg::*;

   // op codes with no operation behind them
   localparam logic [OP_W-1:0] OP_NOP_LOW  = 3'd6;
   localparam logic [OP_W-1:0] OP_NOP_HIGH = 3'd7;

   // cycles with neither a word taken nor a reply before the run is abandoned
   localparam int STALL_LIMIT  = 1000;
   // random words in each idle phase
   localparam int PHASE_WORDS  = 450;
   // settling cycles after the last reply
   localparam int DRAIN_CYCLES = 10;

   typedef struct packed {
      logic [OP_W-1:0]     op;
      logic [ELEM_W-1:0]   value;
      status_type          status;
      logic [COUNT_W-1:0]  count;
   } deque_reply_type;

   typedef enum {FILLING, DRAINING, MIXING} traffic_mode_type;

   // ------------------------------------------------------------------------
   // scoreboard: shadow deque plus the replies still owed by the block
   // ------------------------------------------------------------------------
   class deque_scoreboard_type;
      localparam int REPORT_LIMIT = 10;

      logic [ELEM_W-1:0]  ring [CAPACITY];
      logic [SLOT_W-1:0]  head;
      logic [COUNT_W-1:0] held;
      deque_reply_type    awaited[$];
      int                 mismatches;

      function new();
         head = '0;
         held = '0;
         mismatches = 0;
      endfunction

      // apply one accepted word to the shadow deque and queue its reply
      function void note_word(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                              logic [ELEM_W-1:0] value);
         deque_reply_type want;
         logic [SLOT_W-1:0] slot;
         want.op = op;
         want.value = '0;
         want.status = ST_OK;
         case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
               if (held == CAPACITY) begin
                  want.status = ST_FULL;
               end else begin
                  if (op == OP_PUSH_FRONT) begin
                     head = head - 1'b1;
                     slot = head;
                  end else begin
                     slot = head + held[SLOT_W-1:0];
                  end
                  ring[slot] = value;
                  held = held + 1'b1;
                  want.value = value;
               end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
               if (held == 0) begin
                  want.status = ST_EMPTY;
               end else begin
                  held = held - 1'b1;
                  if (op == OP_POP_FRONT) begin
                     want.value = ring[head];
                     head = head + 1'b1;
                  end else begin
                     want.value = ring[head + held[SLOT_W-1:0]];
                  end
               end
            end
            OP_GET, OP_PUT: begin
               if (pos >= held) begin
                  want.status = ST_RANGE;
               end else begin
                  slot = head + pos;
                  want.value = ring[slot];
                  if (op == OP_PUT) ring[slot] = value;
               end
            end
            default: ;
         endcase
         want.count = held;
         awaited.push_back(want);
      endfunction

      // compare one strobed reply with the oldest one owed
      function void check_reply(logic [ELEM_W-1:0] value, logic [STATUS_W-1:0] status,
                                logic [COUNT_W-1:0] count);
         deque_reply_type want;
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("reply with none owed: value %h status %0d count %0d",
                        value, status, count);
            return;
         end
         want = awaited.pop_front();
         if (value !== want.value || status !== want.status || count !== want.count) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("bad reply to op %0d: value %h/%h status %0d/%0d count %0d/%0d",
                        want.op, want.value, value, want.status, status,
                        want.count, count);
         end
      endfunction
   endclass

   // ------------------------------------------------------------------------
   // clock, reset and block
   // ------------------------------------------------------------------------
   logic                 clock = 1'b0;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [OP_W-1:0]      req_op;
   logic [POS_W-1:0]     req_position;
   logic [ELEM_W-1:0]    req_value_in;
   logic                 rsp_valid;
   logic [ELEM_W-1:0]    rsp_value_out;
   logic [STATUS_W-1:0]  rsp_status;
   logic [COUNT_W-1:0]   rsp_count;

   deque_scoreboard_type replies;
   int                   quiet_cycles;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   circular_deque uut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_op        (req_op),
      .req_position  (req_position),
      .req_value_in  (req_value_in),
      .rsp_valid     (rsp_valid),
      .rsp_value_out (rsp_value_out),
      .rsp_status    (rsp_status),
      .rsp_count     (rsp_count)
   );

   // ------------------------------------------------------------------------
   // monitor: everything is sampled on the rising edge, before the block's
   // registers move, so words and replies are seen as the block saw them
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         // a reply never belongs to the word taken on the same edge
         if (rsp_valid) replies.check_reply(rsp_value_out, rsp_status, rsp_count);
         if (start && !busy) replies.note_word(req_op, req_position, req_value_in);

         // watchdog: only progress on either side clears it
         if (rsp_valid || (start && !busy)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // driver: called at a falling edge, returns at a falling edge after the
   // word is taken; start keeps its value between words so it is assigned
   // once per step at most
   // ------------------------------------------------------------------------
   task automatic send_word(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                            input logic [ELEM_W-1:0] value, input int idle_pct);
      // random sender gaps, each idle step rolled anew
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start        <= 1'b1;
      req_op       <= op;
      req_position <= pos;
      req_value_in <= value;
      // busy as seen at the edge decides acceptance, same as the monitor
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   // element values lean on the all-zero and all-one corners now and then
   function automatic logic [ELEM_W-1:0] pick_value();
      int roll;
      roll = $urandom_range(9);
      if (roll == 0) return '0;
      if (roll == 1) return '1;
      return $urandom();
   endfunction

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   initial begin
      int                 idle_by_phase [4];
      int                 i;
      int                 phase;
      int                 roll;
      int                 push_weight;
      int                 pop_weight;
      int                 mode_left;
      traffic_mode_type   mode;
      logic [OP_W-1:0]    op;
      logic [POS_W-1:0]   pos;

      // no idling, heavy idling, no idling again (receiver cannot stall),
      // light idling
      idle_by_phase = '{0, 63, 0, 19};

      start        = 1'b0;
      req_op       = '0;
      req_position = '0;
      req_value_in = '0;
      reset        = 1'b1;
      replies      = new();

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // ---- directed: refusals on an empty deque and idle op codes ----
      send_word(OP_POP_FRONT, 4'd0, '1, 0);
      send_word(OP_POP_BACK, 4'd15, '0, 0);
      send_word(OP_GET, 4'd0, '0, 0);
      send_word(OP_PUT, 4'd15, '1, 0);
      send_word(OP_NOP_LOW, 4'd15, '1, 0);
      send_word(OP_NOP_HIGH, 4'd0, 32'h5a5a_a5a5, 0);

      // fill to capacity from both ends, corner values first
      for (i = 0; i < CAPACITY; i++) begin
         send_word(i[0] ? OP_PUSH_BACK : OP_PUSH_FRONT, i[POS_W-1:0],
                   (i == 0) ? '0 : (i == 1) ? '1 : $urandom(), 0);
      end

      // refusals on a full deque, then the last and first index
      send_word(OP_PUSH_FRONT, 4'd3, 32'hdead_beef, 0);
      send_word(OP_PUSH_BACK, 4'd7, 32'hcafe_f00d, 0);
      send_word(OP_GET, 4'd15, '0, 0);
      send_word(OP_PUT, 4'd15, '0, 0);
      send_word(OP_PUT, 4'd0, '1, 0);

      // ---- random: traffic drifts between filling, draining and mixed ----
      mode = MIXING;
      mode_left = 0;
      for (phase = 0; phase < 4; phase++) begin
         for (i = 0; i < PHASE_WORDS; i++) begin
            if (mode_left == 0) begin
               roll = $urandom_range(2);
               mode = (roll == 0) ? FILLING : (roll == 1) ? DRAINING : MIXING;
               mode_left = $urandom_range(60, 20);
            end
            mode_left--;

            case (mode)
               FILLING:  begin push_weight = 60; pop_weight = 10; end
               DRAINING: begin push_weight = 10; pop_weight = 60; end
               default:  begin push_weight = 33; pop_weight = 33; end
            endcase

            // a few idle op codes, then pushes, pops, get and put
            roll = $urandom_range(99);
            if (roll < 3)
               op = $urandom_range(1) ? OP_NOP_HIGH : OP_NOP_LOW;
            else if (roll < 3 + push_weight)
               op = $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
            else if (roll < 3 + push_weight + pop_weight)
               op = $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
            else
               op = $urandom_range(1) ? OP_PUT : OP_GET;

            // mostly an index inside the count, sometimes anywhere
            if (replies.held != 0 && $urandom_range(3) != 0)
               pos = POS_W'($urandom_range(replies.held - 1));
            else
               pos = POS_W'($urandom_range(CAPACITY - 1));

            send_word(op, pos, pick_value(), idle_by_phase[phase]);
         end
      end

      // ---- wind down ----
      start <= 1'b0;
      while (replies.awaited.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (replies.mismatches == 0 && replies.awaited.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

FILE: circular_deque.f
sv/cdq_pkg.sv
sv/cdq_ctrl.sv
sv/cdq_datapath.sv
sv/circular_deque.sv
tb/circular_deque_tb.sv
